>>> rtl/core/ffha_pkg.sv
// Shared types, codes and constants of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int POS_W       = 18;
	localparam int HDR_W       = 17;
	localparam int REQ_W       = 16;
	localparam int OFF_W       = 15;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int ALIGN_BYTES = 8;
	localparam int ALIGN_SH    = $clog2(ALIGN_BYTES);
	localparam int MIN_BLOCK   = 16;

	localparam logic [CFG_W-1:0] HEAP_BYTES_RST  = 16'h8000;
	localparam logic [CFG_W-1:0] MAX_REQUEST_RST = 16'h8000;

	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_MALLOC = 2'd1,
		CMD_FREE   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_ZERO      = 3'd1,
		STAT_NO_MEM    = 3'd2,
		STAT_TOO_LARGE = 3'd3,
		STAT_NO_FIT    = 3'd4,
		STAT_SMALL     = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_BYTES  = 1'b0,
		CFG_MAX_REQUEST = 1'b1
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_ROOM,
		ST_LIMIT,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_WALK_NEXT,
		ST_SPLIT_ADDR,
		ST_SPLIT_WR,
		ST_USED_HDR,
		ST_MARK,
		ST_FREE_CHK,
		ST_FREE_RD,
		ST_FREE_CLR,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [REQ_W-1:0] request_bytes;
		logic [OFF_W-1:0] payload_offset;
	} cmd_payload_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [OFF_W-1:0] result_offset;
	} rsp_payload_t;

	// One request to the shared add/subtract/compare unit.
	typedef struct packed {
		logic             sub;
		logic [POS_W-1:0] a;
		logic [POS_W-1:0] b;
		logic [POS_W-1:0] c;
	} alu_op_t;

	typedef struct packed {
		logic [POS_W-1:0] r;
		logic             flow;   // carry on add, borrow on subtract
		logic             gt;     // r >  c
		logic             ge;     // r >= c
	} alu_res_t;

	// Payload size of a header: drop the used bit.
	function automatic logic [HDR_W-1:0] hdr_size(input logic [HDR_W-1:0] h);
		return {h[HDR_W-1:1], 1'b0};
	endfunction

endpackage

>>> rtl/core/ffha_if.sv
// Valid/ready channel interfaces for allocator commands and results.
`timescale 1ns / 1ps

interface ffha_cmd_if;
	import ffha_pkg::*;
	logic         valid;
	logic         ready;
	cmd_payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ffha_rsp_if;
	import ffha_pkg::*;
	logic         valid;
	logic         ready;
	rsp_payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: configuration registers and instances.
`timescale 1ns / 1ps

// First-fit allocator over an implicit list of 8-byte headers held in an on-chip header
// memory of HEAP_WORDS words. One command is worked at a time; cmd.ready is high only
// while the sequencer is idle, and a finished result waits in the rsp output register
// so the next command can be taken meanwhile. All additions and subtractions run through
// a single shared add/compare unit, and the header memory has one read and one write
// port with a registered read. Malloc rounds the request, checks it against the room
// left and max_request, then reads and checks one header after another, splits the
// chosen block when enough is left over, and marks it used. A result that is not taken
// holds the sequencer in its done step until the output register frees up. The header
// memory is not cleared at reset; init must run before malloc can succeed. The user must
// write heap_bytes and max_request through the cfg port only while no command is in
// flight; the block itself does not enforce this.
module first_fit_heap_allocator_core #(
	parameter int HEAP_WORDS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ffha_cmd_if.sink                       cmd,
	ffha_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffha_pkg::CFG_W-1:0]     cfg_data
);
	import ffha_pkg::*;

	localparam int AW = $clog2(HEAP_WORDS);

	logic [CFG_W-1:0] heap_bytes_q;
	logic [CFG_W-1:0] max_request_q;

	logic             hdr_we;
	logic [AW-1:0]    hdr_waddr;
	logic [HDR_W-1:0] hdr_wdata;
	logic             hdr_re;
	logic [AW-1:0]    hdr_raddr;
	logic [HDR_W-1:0] hdr_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_bytes_q  <= HEAP_BYTES_RST;
			max_request_q <= MAX_REQUEST_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_HEAP_BYTES:  heap_bytes_q  <= cfg_data;
				CFG_MAX_REQUEST: max_request_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ffha_hdr_mem #(
		.DEPTH (HEAP_WORDS),
		.AW    (AW)
	) u_hdr_mem (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.re    (hdr_re),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	ffha_ctrl #(
		.HEAP_WORDS (HEAP_WORDS),
		.AW         (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.heap_bytes  (heap_bytes_q),
		.max_request (max_request_q),
		.hdr_we      (hdr_we),
		.hdr_waddr   (hdr_waddr),
		.hdr_wdata   (hdr_wdata),
		.hdr_re      (hdr_re),
		.hdr_raddr   (hdr_raddr),
		.hdr_rdata   (hdr_rdata)
	);

endmodule

>>> rtl/core/ffha_alu.sv
// Shared add/subtract unit with a magnitude compare against a third operand.
`timescale 1ns / 1ps

module ffha_alu (
	input  ffha_pkg::alu_op_t  op,
	output ffha_pkg::alu_res_t res
);
	import ffha_pkg::*;

	logic [POS_W:0] ext;

	always_comb begin
		ext = {1'b0, op.a} + ({1'b0, op.b} ^ {(POS_W+1){op.sub}}) + (POS_W+1)'(op.sub);
		res.r    = ext[POS_W-1:0];
		res.flow = ext[POS_W];
		res.gt   = ext[POS_W-1:0] > op.c;
		res.ge   = ext[POS_W-1:0] >= op.c;
	end

endmodule

>>> rtl/core/ffha_hdr_mem.sv
// Header memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ffha_hdr_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ffha_pkg::HDR_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [ffha_pkg::HDR_W-1:0] rdata
);
	import ffha_pkg::*;

	logic [HDR_W-1:0] hdr_mem_q [DEPTH];
	logic [HDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			hdr_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= hdr_mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ffha_ctrl.sv
// Command sequencer: init, first-fit walk with split, free, result register.
`timescale 1ns / 1ps

module ffha_ctrl #(
	parameter int HEAP_WORDS = 4096,
	parameter int AW         = $clog2(HEAP_WORDS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ffha_cmd_if.sink                   cmd,
	ffha_rsp_if.source                 rsp,
	input  logic [ffha_pkg::CFG_W-1:0] heap_bytes,
	input  logic [ffha_pkg::CFG_W-1:0] max_request,
	output logic                       hdr_we,
	output logic [AW-1:0]              hdr_waddr,
	output logic [ffha_pkg::HDR_W-1:0] hdr_wdata,
	output logic                       hdr_re,
	output logic [AW-1:0]              hdr_raddr,
	input  logic [ffha_pkg::HDR_W-1:0] hdr_rdata
);
	import ffha_pkg::*;

	localparam int HEAP_CAP = HEAP_WORDS * ALIGN_BYTES;

	ctrl_state_t state_q, state_d;

	logic [1:0]       cmd_q;
	logic [REQ_W-1:0] req_q;
	logic [OFF_W-1:0] off_q;
	logic [HDR_W-1:0] need_q;
	logic [HDR_W-1:0] used_q;
	logic [CFG_W-1:0] limit_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos8_q;
	logic [POS_W-1:0] split_q;
	logic [HDR_W-1:0] size_q;
	logic [HDR_W-1:0] rest_q;
	status_t          status_q;
	logic [OFF_W-1:0] granted_q;
	logic             out_valid_q;
	status_t          rsp_status_q;
	logic [OFF_W-1:0] rsp_offset_q;

	alu_op_t  alu_op;
	alu_res_t alu_res;

	logic [CFG_W-1:0] lim_raw;
	logic [CFG_W-1:0] lim;
	logic             init_small;
	logic [HDR_W-1:0] rd_size;
	logic             fit;
	logic             split;
	logic             off_bad;
	logic             split_in_range;
	logic             load;

	ffha_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	always_comb begin
		lim_raw        = heap_bytes & ~CFG_W'(ALIGN_BYTES - 1);
		lim            = (32'(lim_raw) > HEAP_CAP) ? CFG_W'(HEAP_CAP) : lim_raw;
		init_small     = lim < CFG_W'(MIN_BLOCK);
		rd_size        = hdr_size(hdr_rdata);
		fit            = !hdr_rdata[0] && !alu_res.flow;
		split          = alu_res.r[HDR_W-1:0] >= HDR_W'(MIN_BLOCK);
		off_bad        = (off_q == '0) || ((off_q & OFF_W'(ALIGN_BYTES - 1)) != '0);
		split_in_range = (32'(split_q) >> ALIGN_SH) < 32'(HEAP_WORDS);
		load           = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					case (cmd.payload.command)
						CMD_INIT:   state_d = ST_INIT;
						CMD_MALLOC: state_d = ST_ROUND;
						CMD_FREE:   state_d = ST_FREE_CHK;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_INIT:       state_d = ST_DONE;
			ST_ROUND:      state_d = (req_q == '0) ? ST_DONE : ST_ROOM;
			ST_ROOM:       state_d = alu_res.gt ? ST_DONE : ST_LIMIT;
			ST_LIMIT:      state_d = alu_res.gt ? ST_DONE : ST_WALK_RD;
			ST_WALK_RD:    state_d = ST_WALK_CHK;
			ST_WALK_CHK: begin
				if (fit) begin
					state_d = split ? ST_SPLIT_ADDR : ST_MARK;
				end else begin
					state_d = ST_WALK_NEXT;
				end
			end
			ST_WALK_NEXT:  state_d = alu_res.ge ? ST_DONE : ST_WALK_RD;
			ST_SPLIT_ADDR: state_d = ST_SPLIT_WR;
			ST_SPLIT_WR:   state_d = ST_USED_HDR;
			ST_USED_HDR:   state_d = ST_MARK;
			ST_MARK:       state_d = ST_DONE;
			ST_FREE_CHK:   state_d = (off_bad || alu_res.ge) ? ST_DONE : ST_FREE_RD;
			ST_FREE_RD:    state_d = ST_FREE_CLR;
			ST_FREE_CLR:   state_d = ST_DONE;
			ST_DONE:       state_d = load ? ST_IDLE : ST_DONE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Unit operands, memory strobes, handshake
	always_comb begin
		alu_op    = '0;
		hdr_we    = 1'b0;
		hdr_waddr = AW'(pos_q >> ALIGN_SH);
		hdr_wdata = '0;
		hdr_re    = 1'b0;
		hdr_raddr = AW'(pos_q >> ALIGN_SH);
		cmd.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_INIT: begin
				alu_op    = '{sub: 1'b1, a: POS_W'(lim), b: POS_W'(ALIGN_BYTES), c: '0};
				hdr_we    = !init_small;
				hdr_waddr = '0;
				hdr_wdata = alu_res.r[HDR_W-1:0];
			end
			ST_ROUND: begin
				alu_op = '{sub: 1'b0, a: POS_W'(req_q), b: POS_W'(ALIGN_BYTES - 1), c: '0};
			end
			ST_ROOM: begin
				alu_op = '{sub: 1'b0, a: POS_W'(need_q), b: POS_W'(used_q),
					c: POS_W'(limit_q)};
			end
			ST_LIMIT: begin
				alu_op = '{sub: 1'b0, a: POS_W'(need_q), b: '0, c: POS_W'(max_request)};
			end
			ST_WALK_RD: begin
				hdr_re = 1'b1;
				alu_op = '{sub: 1'b0, a: pos_q, b: POS_W'(ALIGN_BYTES), c: '0};
			end
			ST_WALK_CHK: begin
				alu_op = '{sub: 1'b1, a: POS_W'(rd_size), b: POS_W'(need_q), c: '0};
			end
			ST_WALK_NEXT: begin
				alu_op = '{sub: 1'b0, a: pos8_q, b: POS_W'(size_q), c: POS_W'(limit_q)};
			end
			ST_SPLIT_ADDR: begin
				alu_op = '{sub: 1'b0, a: pos8_q, b: POS_W'(need_q), c: '0};
			end
			ST_SPLIT_WR: begin
				alu_op    = '{sub: 1'b1, a: POS_W'(rest_q), b: POS_W'(ALIGN_BYTES), c: '0};
				hdr_we    = split_in_range;
				hdr_waddr = AW'(split_q >> ALIGN_SH);
				hdr_wdata = alu_res.r[HDR_W-1:0];
			end
			ST_USED_HDR: begin
				alu_op = '{sub: 1'b0, a: POS_W'(used_q), b: POS_W'(ALIGN_BYTES), c: '0};
			end
			ST_MARK: begin
				alu_op    = '{sub: 1'b0, a: POS_W'(used_q), b: POS_W'(need_q), c: '0};
				hdr_we    = 1'b1;
				hdr_wdata = {need_q[HDR_W-1:1], 1'b1};
			end
			ST_FREE_CHK: begin
				alu_op = '{sub: 1'b1, a: POS_W'(off_q), b: POS_W'(ALIGN_BYTES),
					c: POS_W'(limit_q)};
			end
			ST_FREE_RD: begin
				hdr_re = 1'b1;
			end
			ST_FREE_CLR: begin
				alu_op    = '{sub: 1'b1, a: POS_W'(used_q), b: POS_W'(rd_size), c: '0};
				hdr_we    = hdr_rdata[0];
				hdr_wdata = rd_size;
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT: begin
					if (!init_small) begin
						limit_q <= lim;
						used_q  <= HDR_W'(ALIGN_BYTES);
					end
				end
				ST_USED_HDR, ST_MARK: used_q <= alu_res.r[HDR_W-1:0];
				ST_FREE_CLR: begin
					if (hdr_rdata[0]) begin
						used_q <= alu_res.r[HDR_W-1:0];
					end
				end
				default: ;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					cmd_q     <= cmd.payload.command;
					req_q     <= cmd.payload.request_bytes;
					off_q     <= cmd.payload.payload_offset;
					status_q  <= STAT_OK;
					granted_q <= '0;
					pos_q     <= '0;
				end
			end
			ST_INIT: begin
				if (init_small) begin
					status_q <= STAT_SMALL;
				end
			end
			ST_ROUND: begin
				need_q <= alu_res.r[HDR_W-1:0] & ~HDR_W'(ALIGN_BYTES - 1);
				if (req_q == '0) begin
					status_q <= STAT_ZERO;
				end
			end
			ST_ROOM: begin
				if (alu_res.gt) begin
					status_q <= STAT_NO_MEM;
				end
			end
			ST_LIMIT: begin
				if (alu_res.gt) begin
					status_q <= STAT_TOO_LARGE;
				end
			end
			ST_WALK_RD: pos8_q <= alu_res.r;
			ST_WALK_CHK: begin
				size_q <= rd_size;
				rest_q <= alu_res.r[HDR_W-1:0];
				// too little left over to split: take the whole block
				if (fit && !split) begin
					need_q <= rd_size;
				end
			end
			ST_WALK_NEXT: begin
				pos_q <= alu_res.r;
				if (alu_res.ge) begin
					status_q <= STAT_NO_FIT;
				end
			end
			ST_SPLIT_ADDR: split_q <= alu_res.r;
			ST_MARK: granted_q <= pos8_q[OFF_W-1:0];
			ST_FREE_CHK: pos_q <= alu_res.r;
			ST_DONE: begin
				if (load) begin
					rsp_status_q <= status_q;
					rsp_offset_q <= granted_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = '{status: rsp_status_q, result_offset: rsp_offset_q};

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q != ST_IDLE))
		else $error("accepted command did not start the sequencer");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_we |-> (state_q == ST_INIT || state_q == ST_SPLIT_WR ||
			state_q == ST_MARK || state_q == ST_FREE_CLR))
		else $error("header write outside a writing step");

	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_CHK) |-> ($past(state_q) == ST_WALK_RD))
		else $error("header check without a preceding read");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result beat raised outside the done step");

	a_small_only_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && status_q == STAT_SMALL) |-> (cmd_q == CMD_INIT))
		else $error("heap-too-small status on a non-init command");

endmodule

>>> tb/tb_first_fit_heap_allocator_core.sv
// Self-checking testbench for the first-fit heap allocator core.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_core;
	import ffha_pkg::*;

	localparam int HEAP_WORDS = 4096;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int unsigned BYTES_MASK = 32'h1FFFF;
	localparam int unsigned HEAP_CAP = HEAP_WORDS * ALIGN_BYTES;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Mirror of the header list, the used count and the registers.
	class alloc_scoreboard;
		logic [HDR_W-1:0] hdr_mem [HEAP_WORDS];
		int unsigned heap_cfg;
		int unsigned max_req_cfg;
		int unsigned used;
		int unsigned limit;
		rsp_payload_t pending[$];
		int unsigned live[$];
		int unsigned granted[$];
		int errors;
		int results_seen;

		function new();
			foreach (hdr_mem[i]) hdr_mem[i] = '0;
			heap_cfg = 32'(HEAP_BYTES_RST);
			max_req_cfg = 32'(MAX_REQUEST_RST);
			used = 0;
			limit = 0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
			if (idx == CFG_HEAP_BYTES) begin
				heap_cfg = 32'(value);
			end else begin
				max_req_cfg = 32'(value);
			end
		endfunction

		function void note_command(cmd_payload_t c);
			rsp_payload_t exp;
			int unsigned lim, req, need, pos, size, rest, off;
			logic [HDR_W-1:0] h;
			bit hit;
			exp = '0;
			exp.status = STAT_OK;
			case (c.command)
				CMD_INIT: begin
					lim = heap_cfg & ~(ALIGN_BYTES - 1);
					if (lim > HEAP_CAP) lim = HEAP_CAP;
					if (lim < MIN_BLOCK) begin
						exp.status = STAT_SMALL;
					end else begin
						limit = lim;
						hdr_mem[0] = HDR_W'(lim - ALIGN_BYTES);
						used = ALIGN_BYTES;
						// offsets of the old list are stale from here on
						live.delete();
						granted.delete();
					end
				end
				CMD_MALLOC: begin
					req = 32'(c.request_bytes);
					need = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
					if (req == 0) begin
						exp.status = STAT_ZERO;
					end else if (need + used > limit) begin
						exp.status = STAT_NO_MEM;
					end else if (need > max_req_cfg) begin
						exp.status = STAT_TOO_LARGE;
					end else begin
						exp.status = STAT_NO_FIT;
						pos = 0;
						hit = 1'b0;
						while (!hit && pos < limit) begin
							h = hdr_mem[pos / ALIGN_BYTES];
							size = 32'({h[HDR_W-1:1], 1'b0});
							if (!h[0] && need <= size) begin
								rest = size - need;
								if (rest < MIN_BLOCK) begin
									need = size;
								end else begin
									hdr_mem[(pos + ALIGN_BYTES + need) / ALIGN_BYTES] =
										HDR_W'(rest - ALIGN_BYTES);
									used = (used + ALIGN_BYTES) & BYTES_MASK;
								end
								hdr_mem[pos / ALIGN_BYTES] = HDR_W'(need | 1);
								used = (used + need) & BYTES_MASK;
								exp.status = STAT_OK;
								exp.result_offset = OFF_W'(pos + ALIGN_BYTES);
								live.push_back(pos + ALIGN_BYTES);
								granted.push_back(pos + ALIGN_BYTES);
								hit = 1'b1;
							end else begin
								pos = pos + ALIGN_BYTES + size;
							end
						end
					end
				end
				CMD_FREE: begin
					off = 32'(c.payload_offset);
					if (off != 0 && off % ALIGN_BYTES == 0 && off - ALIGN_BYTES < limit) begin
						h = hdr_mem[(off - ALIGN_BYTES) / ALIGN_BYTES];
						if (h[0]) begin
							hdr_mem[(off - ALIGN_BYTES) / ALIGN_BYTES] = {h[HDR_W-1:1], 1'b0};
							used = (used - 32'({h[HDR_W-1:1], 1'b0})) & BYTES_MASK;
							hit = 1'b0;
							for (int i = 0; i < live.size() && !hit; i++) begin
								if (live[i] == off) begin
									live.delete(i);
									hit = 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
			pending.push_back(exp);
		endfunction

		function void flag(string what, rsp_payload_t exp, rsp_payload_t got);
			errors++;
			if (errors <= 10)
				$display("%s at result %0d: exp status %0d offset %0d, got status %0d offset %0d",
					what, results_seen, exp.status, exp.result_offset,
					got.status, got.result_offset);
		endfunction

		function void check_result(rsp_payload_t got);
			rsp_payload_t exp;
			results_seen++;
			if (pending.size() == 0) begin
				flag("unexpected result", '0, got);
			end else begin
				exp = pending.pop_front();
				if (got.status !== exp.status)
					flag("status mismatch", exp, got);
				else if (got.result_offset !== exp.result_offset)
					flag("offset mismatch", exp, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int cycles = 0;
	int calm_src = 0;
	bit quiet = 1'b0;

	ffha_cmd_if cmd_ch();
	ffha_rsp_if rsp_ch();

	alloc_scoreboard sb = new();

	first_fit_heap_allocator_core #(
		.HEAP_WORDS(HEAP_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.rsp(rsp_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_first_fit_heap_allocator_core: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.payload);
	end

	// Result side: short stalls, each followed by a run of ready cycles.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet || $urandom_range(0, 3) != 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
				@(negedge clk);
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	function automatic int source_gap();
		if (quiet) return 0;
		if (calm_src > 0) begin
			calm_src--;
			return 0;
		end
		calm_src = $urandom_range(0, 15);
		return $urandom_range(1, 6);
	endfunction

	function automatic cmd_payload_t make_cmd(logic [1:0] command, int unsigned req,
		int unsigned off);
		cmd_payload_t it;
		it.command = command;
		it.request_bytes = REQ_W'(req);
		it.payload_offset = OFF_W'(off);
		return it;
	endfunction

	function automatic cmd_payload_t next_random_cmd();
		cmd_payload_t it;
		int unsigned pick, k, span;
		it.command = CMD_MALLOC;
		it.request_bytes = REQ_W'($urandom());
		it.payload_offset = OFF_W'($urandom());
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 99);
		span = (sb.limit / 8 > 0) ? sb.limit / 8 : 1;
		if (pick < 3) begin
			it.command = CMD_INIT;
		end else if (pick < 6) begin
			it.command = CMD_UNUSED;
		end else if (pick < 60) begin
			if (k < 55)
				it.request_bytes = REQ_W'($urandom_range(1, span));
			else if (k < 75)
				it.request_bytes = REQ_W'($urandom_range(1, 64));
			else if (k < 85)
				it.request_bytes = REQ_W'($urandom_range(1, span * 8));
			else if (k < 93)
				it.request_bytes = REQ_W'($urandom());
			else if (k < 95)
				it.request_bytes = '0;
			else if (k < 97)
				it.request_bytes = 16'hFFFF;
			else if (k < 99)
				it.request_bytes = REQ_W'(sb.max_req_cfg);
			else
				it.request_bytes = REQ_W'(sb.max_req_cfg + 1);
		end else begin
			it.command = CMD_FREE;
			if (k < 65 && sb.live.size() > 0)
				it.payload_offset = OFF_W'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
			else if (k < 75 && sb.granted.size() > 0)
				it.payload_offset =
					OFF_W'(sb.granted[$urandom_range(0, sb.granted.size() - 1)]);
			else if (k < 82)
				it.payload_offset = '0;
			else if (k < 91 && sb.limit <= HEAP_CAP - 16)
				it.payload_offset =
					OFF_W'($urandom_range((sb.limit + 8) / 8, HEAP_WORDS - 1) * 8);
			else
				it.payload_offset =
					OFF_W'(($urandom_range(0, 32767) & ~7) | $urandom_range(1, 7));
		end
		return it;
	endfunction

	// Present one command beat and hold it until the core takes it.
	task automatic send(cmd_payload_t it);
		int gap;
		gap = source_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= it;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(it);
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(logic [CFG_W-1:0] heap, logic [CFG_W-1:0] max_req);
		drain();
		write_reg(CFG_HEAP_BYTES, heap);
		write_reg(CFG_MAX_REQUEST, max_req);
	endtask

	int heap_list [11] = '{256, 1024, 2048, 512, 32768, 4096, 1003, 16, 8192, 65535, 1536};
	int max_list [11] = '{32768, 32768, 512, 64, 32768, 0, 65535, 16, 1024, 40000, 32768};
	int count_list [11] = '{80, 100, 90, 60, 50, 20, 80, 20, 80, 40, 80};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// before init, null and unknown commands, then a full heap
		send(make_cmd(CMD_MALLOC, 8, 0));
		send(make_cmd(CMD_MALLOC, 0, 32'h7FFF));
		send(make_cmd(CMD_FREE, 32'hFFFF, 8));
		send(make_cmd(CMD_FREE, 0, 0));
		send(make_cmd(CMD_UNUSED, 32'hFFFF, 32'h7FFF));
		send(make_cmd(CMD_INIT, 0, 0));
		send(make_cmd(CMD_MALLOC, 1, 0));
		send(make_cmd(CMD_MALLOC, 32'hFFFF, 0));
		send(make_cmd(CMD_FREE, 0, 32'h7FFF));
		send(make_cmd(CMD_FREE, 0, 8));
		send(make_cmd(CMD_FREE, 0, 8));
		send(make_cmd(CMD_MALLOC, 8, 0));

		// oversized heap clamps; zero request limit
		setup(16'hFFFF, 16'd0);
		send(make_cmd(CMD_INIT, 0, 0));
		send(make_cmd(CMD_MALLOC, 1, 0));

		// heaps too small leave the old heap in place
		setup(16'd15, 16'd0);
		send(make_cmd(CMD_INIT, 0, 0));
		setup(16'd0, 16'hFFFF);
		send(make_cmd(CMD_INIT, 0, 0));

		// unaligned size rounds down to the smallest heap
		setup(16'd20, 16'hFFFF);
		send(make_cmd(CMD_INIT, 0, 0));
		send(make_cmd(CMD_MALLOC, 8, 0));
		send(make_cmd(CMD_MALLOC, 1, 0));

		// fragment a small heap until nothing fits
		setup(16'd64, 16'hFFFF);
		send(make_cmd(CMD_INIT, 0, 0));
		send(make_cmd(CMD_MALLOC, 8, 0));
		send(make_cmd(CMD_MALLOC, 8, 0));
		send(make_cmd(CMD_FREE, 0, 8));
		send(make_cmd(CMD_MALLOC, 16, 0));
		send(make_cmd(CMD_FREE, 0, 24));
		send(make_cmd(CMD_MALLOC, 16, 0));
		send(make_cmd(CMD_FREE, 0, 32'h7FF8));

		for (int p = 0; p < 11; p++) begin
			setup(CFG_W'(heap_list[p]), CFG_W'(max_list[p]));
			if (p == 10) quiet = 1'b1;
			send(make_cmd(CMD_INIT, $urandom(), $urandom()));
			for (int n = 1; n < count_list[p]; n++)
				send(next_random_cmd());
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_first_fit_heap_allocator_core: clean");
		end else begin
			$display("tb_first_fit_heap_allocator_core: errors");
		end
		$finish;
	end

endmodule
